// ----- rtl/core/rcs_pkg.sv -----
// shared constants, types and arithmetic helpers for the retention curve core
// log2 squaring step, exp2 root multiply, root table and shift helpers
// no dependencies
package rcs_pkg;

    localparam int LOG_STEPS  = 32;
    localparam int EXP_STEPS  = 32;
    localparam int DIV_STEPS  = 44;
    localparam int PIPE_DEPTH = 2 * LOG_STEPS + 2 * EXP_STEPS + DIV_STEPS + 14;
    localparam int CNT_W      = $clog2(LOG_STEPS);

    localparam logic [31:0] ENTRY_RESET = 32'd2560000;
    localparam logic [19:0] SHAPE_RESET = 20'd131072;
    localparam logic [19:0] SHAPE_MIN   = 20'd65537;
    localparam logic [19:0] ONE_Q16_20  = 20'd65536;
    localparam logic [17:0] ONE_Q16_18  = 18'd65536;
    localparam logic [16:0] SAT_ONE     = 17'h1_0000;
    localparam logic [39:0] KC_BIAS     = 40'h08_0000_0000;
    localparam logic [31:0] ACC_ONE     = 32'h8000_0000;
    localparam logic [63:0] ONE60       = 64'h1000_0000_0000_0000;
    localparam logic [63:0] CAP60       = 64'h1000_0000_0000_0000;
    localparam logic [63:0] CAP32       = 64'h0000_0001_0000_0000;
    localparam logic [63:0] CAP47       = 64'h0000_8000_0000_0000;
    localparam logic [49:0] RND_HALF    = 50'h8000_0000;

    typedef enum logic [1:0] {
        REG_ENTRY,
        REG_RES_L,
        REG_RES_G,
        REG_SHAPE
    } t_reg_idx;

    typedef struct packed {
        logic [19:0] n;
        logic [19:0] nm1;
        logic [16:0] span;
        logic [15:0] res_l;
        logic [37:0] lb;
        logic [39:0] kc;
        logic        busy;
    } t_cfg;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = x;
        r = 64'd0;
        for (int j = 0; j < 32; j++) begin
            b = 64'd1 << (62 - 2 * j);
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic [32:1][31:0] build_roots();
        logic [32:1][31:0] t;
        logic [63:0] r;
        r = isqrt64(64'h8000_0000_0000_0000);
        t[1] = r[31:0];
        for (int i = 2; i <= 32; i++) begin
            r = isqrt64({r[32:0], 31'b0});
            t[i] = r[31:0];
        end
        return t;
    endfunction

    localparam logic [32:1][31:0] ROOTS = build_roots();

    function automatic logic [5:0] msb_pos(input logic [63:0] v);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) p = 6'(i);
        end
        return p;
    endfunction

    function automatic logic [31:0] norm_q31(input logic [63:0] v, input logic [5:0] p);
        logic [94:0] t;
        t = {v, 31'b0} >> p;
        return t[31:0];
    endfunction

    // one squaring step: {fraction bit, next mantissa}
    function automatic logic [32:0] log_step(input logic [31:0] m);
        logic [63:0] sq;
        sq = 64'(m) * 64'(m);
        if (sq[63]) begin
            return {1'b1, sq[63:32]};
        end else begin
            return {1'b0, sq[62:31]};
        end
    endfunction

    function automatic logic [31:0] exp_mul(input logic [31:0] acc, input logic [31:0] root);
        logic [63:0] pr;
        pr = 64'(acc) * 64'(root);
        return pr[62:31];
    endfunction

    // final shift of exp2: {overflow, value}
    function automatic logic [64:0] exp_fin(input logic [31:0] acc,
                                            input logic signed [17:0] s);
        logic [63:0] a64;
        logic [63:0] v;
        logic [5:0]  r;
        logic        ovf;
        a64 = 64'(acc);
        v   = 64'd0;
        ovf = 1'b0;
        r   = 6'd0;
        if (s > 18'sd31) begin
            ovf = 1'b1;
        end else if (s >= 18'sd0) begin
            v = a64 << s[4:0];
        end else if (s >= -18'sd40) begin
            r = 6'(-s);
            v = (a64 + (64'd1 << (r - 6'd1))) >> r;
        end
        return {ovf, v};
    endfunction

endpackage

// ----- rtl/core/rcs_cfg.sv -----
// configuration registers and the derived curve constants
// evaluates log2 of entry pressure, n-1 and span with one shared squaring unit
// depends on rcs_pkg
module rcs_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output rcs_pkg::t_cfg       o_cfg
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SQ,
        ST_STORE,
        ST_SUM
    } t_state;

    typedef enum logic [1:0] {
        SEL_B,
        SEL_NM1,
        SEL_SPAN
    } t_sel;

    t_state                    r_state;
    t_sel                      r_sel;
    logic [rcs_pkg::CNT_W-1:0] r_cnt;
    logic [31:0]               r_entry;
    logic [15:0]               r_res_l;
    logic [15:0]               r_res_g;
    logic [19:0]               r_shape;
    logic [31:0]               r_m;
    logic [5:0]                r_p;
    logic [31:0]               r_frac;
    logic [37:0]               r_lb;
    logic [37:0]               r_lnm1;
    logic [37:0]               r_lspan;
    logic [39:0]               r_kc;

    logic [31:0] w_b;
    logic [19:0] w_n;
    logic [19:0] w_nm1;
    logic [17:0] w_sum;
    logic [16:0] w_span;
    logic [63:0] w_src;
    logic [5:0]  w_p;
    logic [32:0] w_step;
    logic [37:0] w_l;

    assign w_b    = (r_entry == 32'd0) ? 32'd1 : r_entry;
    assign w_n    = (r_shape < rcs_pkg::SHAPE_MIN) ? rcs_pkg::SHAPE_MIN : r_shape;
    assign w_nm1  = w_n - rcs_pkg::ONE_Q16_20;
    assign w_sum  = 18'(r_res_l) + 18'(r_res_g);
    assign w_span = (w_sum >= rcs_pkg::ONE_Q16_18) ? 17'd0
                                                    : 17'(rcs_pkg::ONE_Q16_18 - w_sum);

    always_comb begin
        unique case (r_sel)
            SEL_B:    w_src = 64'(w_b);
            SEL_NM1:  w_src = 64'(w_nm1);
            SEL_SPAN: w_src = 64'(w_span);
            default:  w_src = 64'd0;
        endcase
    end

    assign w_p    = rcs_pkg::msb_pos(w_src);
    assign w_step = rcs_pkg::log_step(r_m);
    assign w_l    = {r_p, r_frac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= rcs_pkg::ENTRY_RESET;
            r_res_l <= 16'd0;
            r_res_g <= 16'd0;
            r_shape <= rcs_pkg::SHAPE_RESET;
            r_state <= ST_LOAD;
            r_sel   <= SEL_B;
            r_cnt   <= '0;
        end else if (i_cfg_we) begin
            unique case (rcs_pkg::t_reg_idx'(i_cfg_index))
                rcs_pkg::REG_ENTRY: r_entry <= i_cfg_data;
                rcs_pkg::REG_RES_L: r_res_l <= i_cfg_data[15:0];
                rcs_pkg::REG_RES_G: r_res_g <= i_cfg_data[15:0];
                rcs_pkg::REG_SHAPE: r_shape <= i_cfg_data[19:0];
            endcase
            r_state <= ST_LOAD;
            r_sel   <= SEL_B;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                end
                ST_LOAD: begin
                    r_p     <= w_p;
                    r_m     <= rcs_pkg::norm_q31(w_src, w_p);
                    r_frac  <= 32'd0;
                    r_cnt   <= '0;
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    r_m    <= w_step[31:0];
                    r_frac <= {r_frac[30:0], w_step[32]};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == rcs_pkg::CNT_W'(rcs_pkg::LOG_STEPS - 1)) begin
                        r_state <= ST_STORE;
                    end
                end
                ST_STORE: begin
                    unique case (r_sel)
                        SEL_B: begin
                            r_lb    <= w_l;
                            r_sel   <= SEL_NM1;
                            r_state <= ST_LOAD;
                        end
                        SEL_NM1: begin
                            r_lnm1  <= w_l;
                            r_sel   <= SEL_SPAN;
                            r_state <= ST_LOAD;
                        end
                        default: begin
                            r_lspan <= w_l;
                            r_state <= ST_SUM;
                        end
                    endcase
                end
                ST_SUM: begin
                    r_kc    <= 40'(r_lnm1) + 40'(r_lspan) - 40'(r_lb) + rcs_pkg::KC_BIAS;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_cfg.n     = w_n;
    assign o_cfg.nm1   = w_nm1;
    assign o_cfg.span  = w_span;
    assign o_cfg.res_l = r_res_l;
    assign o_cfg.lb    = r_lb;
    assign o_cfg.kc    = r_kc;
    assign o_cfg.busy  = (r_state != ST_IDLE);

endmodule

// ----- rtl/core/retention_curve_saturation_core.sv -----
// van genuchten retention curve: saturation and slope from capillary pressure
// pipelined log2 / exp2 / divide datapath; depends on rcs_pkg and rcs_cfg
//
// channel   direction  handshake               payload
// request   in         i_valid / o_stall       i_cap_pressure
// result    out        o_valid / i_stall       o_saturation, o_saturation_slope
// config    in         i_cfg_we (no wait)      i_cfg_index, i_cfg_data
//
// one request per cycle while o_stall is low; each result passes through
// the 186 pipeline stages (four 32-step log2/exp2 chains and a
// 44-step divider) and then the output register
// after reset and after each config write o_stall is high while
// the shared squaring unit evaluates the log2 terms of the configuration
// the pipeline halts only when its last stage and the output register are both
// full and i_stall is high
module retention_curve_saturation_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [39:0]  i_cap_pressure,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [16:0]         o_saturation,
    output logic signed [47:0]  o_saturation_slope,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    localparam int LS = rcs_pkg::LOG_STEPS;
    localparam int ES = rcs_pkg::EXP_STEPS;
    localparam int DS = rcs_pkg::DIV_STEPS;
    localparam int PD = rcs_pkg::PIPE_DEPTH;

    rcs_pkg::t_cfg w_cfg;

    rcs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // control
    logic [PD-1:0] r_vld;
    logic [PD-1:0] r_pos;
    logic          r_o_valid;
    logic          w_en;
    logic          w_in_acc;
    logic          w_in_pos;

    // log2 of pressure
    logic [39:0]        r_raw;
    logic [31:0]        r_lm [0:LS];
    logic [31:0]        r_lf [0:LS];
    logic [5:0]         r_lp [0:LS];
    logic [32:0]        w_lstep [1:LS];
    logic [5:0]         w_p0;
    logic signed [39:0] r_lx;
    logic [39:0]        r_c1_lo_n;
    logic [39:0]        r_c1_lo_nm;
    logic signed [40:0] r_c1_hi_n;
    logic signed [40:0] r_c1_hi_nm;
    logic signed [61:0] w_pn;
    logic signed [61:0] w_pa;
    logic signed [44:0] r_t;
    logic signed [44:0] r_a;

    // softplus exp2
    logic signed [44:0] w_u;
    logic [31:0]        r_eacc [0:ES];
    logic [31:0]        r_ef [0:ES];
    logic signed [17:0] r_es [0:ES];
    logic [43:0]        r_ebase [0:ES];
    logic signed [44:0] r_ea [0:ES];
    logic [31:0]        w_emul [1:ES];
    logic [64:0]        w_ffin;
    logic [63:0]        w_z;
    logic [61:0]        r_w;
    logic [43:0]        r_fbase;
    logic signed [44:0] r_fa;

    // softplus log2
    logic [31:0]        r_mm [0:LS];
    logic [31:0]        r_mf [0:LS];
    logic               r_mp61 [0:LS];
    logic [43:0]        r_mbase [0:LS];
    logic signed [44:0] r_ma [0:LS];
    logic [32:0]        w_mstep [1:LS];
    logic [43:0]        w_g;
    logic [43:0]        r_g;
    logic signed [45:0] r_ag;
    logic [41:0]        r_i_lo;
    logic [41:0]        r_i_hi;
    logic signed [45:0] r_i_ag;
    logic [63:0]        w_x;

    // divider
    logic [19:0]        r_drem [0:DS];
    logic [43:0]        r_dq [0:DS];
    logic signed [45:0] r_dag [0:DS];
    logic [20:0]        w_dt [1:DS];
    logic               w_dge [1:DS];

    // final exp2 lanes
    logic signed [45:0] w_ne;
    logic signed [47:0] w_l;
    logic [31:0]        r_xacc1 [0:ES];
    logic [31:0]        r_xacc2 [0:ES];
    logic [31:0]        r_xf1 [0:ES];
    logic [31:0]        r_xf2 [0:ES];
    logic signed [17:0] r_xs1 [0:ES];
    logic signed [17:0] r_xs2 [0:ES];
    logic [31:0]        w_xmul1 [1:ES];
    logic [31:0]        w_xmul2 [1:ES];
    logic [64:0]        w_y1;
    logic [64:0]        w_y2;
    logic [32:0]        r_se;
    logic [47:0]        r_mag;
    logic [49:0]        r_prod;
    logic [47:0]        r_zmag;
    logic [17:0]        w_rnd;
    logic [18:0]        w_sat_sum;
    logic [16:0]        r_o_sat;
    logic [47:0]        r_o_slope;

    assign w_en     = !(r_vld[PD-1] && r_o_valid && i_stall);
    assign o_stall  = w_cfg.busy || !w_en;
    assign w_in_acc = i_valid && !o_stall;
    assign w_in_pos = !i_cap_pressure[39] && (i_cap_pressure != 40'sd0);

    assign o_valid            = r_o_valid;
    assign o_saturation       = r_o_sat;
    assign o_saturation_slope = $signed(r_o_slope);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[PD-2:0], w_in_acc};
            end
            if (!r_o_valid || !i_stall) begin
                r_o_valid <= r_vld[PD-1];
            end
        end
    end

    // combinational step logic
    assign w_p0 = rcs_pkg::msb_pos(64'(r_raw));

    always_comb begin
        for (int i = 1; i <= LS; i++) begin
            w_lstep[i] = rcs_pkg::log_step(r_lm[i-1]);
            w_mstep[i] = rcs_pkg::log_step(r_mm[i-1]);
        end
        for (int i = 1; i <= ES; i++) begin
            w_emul[i]  = rcs_pkg::exp_mul(r_eacc[i-1], rcs_pkg::ROOTS[i]);
            w_xmul1[i] = rcs_pkg::exp_mul(r_xacc1[i-1], rcs_pkg::ROOTS[i]);
            w_xmul2[i] = rcs_pkg::exp_mul(r_xacc2[i-1], rcs_pkg::ROOTS[i]);
        end
        for (int i = 1; i <= DS; i++) begin
            w_dt[i]  = {r_drem[i-1], r_dq[i-1][DS-1]};
            w_dge[i] = (w_dt[i] >= {1'b0, w_cfg.n});
        end
    end

    assign w_pn = (62'(r_c1_hi_n) <<< 20) + $signed({22'b0, r_c1_lo_n});
    assign w_pa = (62'(r_c1_hi_nm) <<< 20) + $signed({22'b0, r_c1_lo_nm});
    assign w_u  = (r_t >= 45'sd0) ? -r_t : r_t;

    assign w_ffin = rcs_pkg::exp_fin(r_eacc[ES], r_es[ES]);
    assign w_z    = w_ffin[64] ? rcs_pkg::CAP60
                  : ((w_ffin[63:0] > rcs_pkg::CAP60) ? rcs_pkg::CAP60 : w_ffin[63:0]);

    assign w_g = r_mbase[LS] + {11'b0, r_mp61[LS], r_mf[LS]};
    assign w_x = {r_i_hi, 22'b0} + 64'(r_i_lo);

    assign w_ne = -$signed({2'b0, r_dq[DS]});
    assign w_l  = 48'(r_dag[DS]) - $signed({4'b0, r_dq[DS]}) + 48'($signed(w_cfg.kc));

    assign w_y1 = rcs_pkg::exp_fin(r_xacc1[ES], r_xs1[ES]);
    assign w_y2 = rcs_pkg::exp_fin(r_xacc2[ES], r_xs2[ES]);

    assign w_rnd     = 18'((r_prod + rcs_pkg::RND_HALF) >> 32);
    assign w_sat_sum = 19'(w_cfg.res_l) + 19'(w_rnd);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_raw <= i_cap_pressure;
            r_pos <= {r_pos[PD-2:0], w_in_pos};

            // pressure log2
            r_lp[0] <= w_p0;
            r_lm[0] <= rcs_pkg::norm_q31(64'(r_raw), w_p0);
            r_lf[0] <= 32'd0;
            for (int i = 1; i <= LS; i++) begin
                r_lm[i] <= w_lstep[i][31:0];
                r_lf[i] <= {r_lf[i-1][30:0], w_lstep[i][32]};
                r_lp[i] <= r_lp[i-1];
            end
            r_lx <= $signed({2'b0, r_lp[LS], r_lf[LS]}) - $signed({2'b0, w_cfg.lb});

            // scale by n and n-1
            r_c1_lo_n  <= 40'(r_lx[19:0]) * 40'(w_cfg.n);
            r_c1_lo_nm <= 40'(r_lx[19:0]) * 40'(w_cfg.nm1);
            r_c1_hi_n  <= $signed(r_lx[39:20]) * $signed({1'b0, w_cfg.n});
            r_c1_hi_nm <= $signed(r_lx[39:20]) * $signed({1'b0, w_cfg.nm1});
            r_t <= $signed(w_pn[60:16]);
            r_a <= $signed(w_pa[60:16]);

            // softplus: 2^-|t|
            r_eacc[0]  <= rcs_pkg::ACC_ONE;
            r_ef[0]    <= w_u[31:0];
            r_es[0]    <= 18'(w_u >>> 32) + 18'sd29;
            r_ebase[0] <= (r_t >= 45'sd0) ? r_t[43:0] : 44'd0;
            r_ea[0]    <= r_a;
            for (int i = 1; i <= ES; i++) begin
                r_eacc[i]  <= r_ef[i-1][ES-i] ? w_emul[i] : r_eacc[i-1];
                r_ef[i]    <= r_ef[i-1];
                r_es[i]    <= r_es[i-1];
                r_ebase[i] <= r_ebase[i-1];
                r_ea[i]    <= r_ea[i-1];
            end
            r_w     <= 62'(w_z) + 62'(rcs_pkg::ONE60);
            r_fbase <= r_ebase[ES];
            r_fa    <= r_ea[ES];

            // softplus: log2(1 + 2^-|t|)
            r_mm[0]    <= r_w[61] ? r_w[61:30] : r_w[60:29];
            r_mp61[0]  <= r_w[61];
            r_mf[0]    <= 32'd0;
            r_mbase[0] <= r_fbase;
            r_ma[0]    <= r_fa;
            for (int i = 1; i <= LS; i++) begin
                r_mm[i]    <= w_mstep[i][31:0];
                r_mf[i]    <= {r_mf[i-1][30:0], w_mstep[i][32]};
                r_mp61[i]  <= r_mp61[i-1];
                r_mbase[i] <= r_mbase[i-1];
                r_ma[i]    <= r_ma[i-1];
            end
            r_g  <= w_g;
            r_ag <= 46'(r_ma[LS]) - $signed({2'b0, w_g});

            // g * (n-1)
            r_i_lo <= 42'(r_g[21:0]) * 42'(w_cfg.nm1);
            r_i_hi <= 42'(r_g[43:22]) * 42'(w_cfg.nm1);
            r_i_ag <= r_ag;

            // divide by n
            r_drem[0] <= w_x[63:44];
            r_dq[0]   <= w_x[43:0];
            r_dag[0]  <= r_i_ag;
            for (int i = 1; i <= DS; i++) begin
                r_drem[i] <= w_dge[i] ? 20'(w_dt[i] - {1'b0, w_cfg.n}) : w_dt[i][19:0];
                r_dq[i]   <= {r_dq[i-1][DS-2:0], w_dge[i]};
                r_dag[i]  <= r_dag[i-1];
            end

            // 2^-e and slope magnitude
            r_xacc1[0] <= rcs_pkg::ACC_ONE;
            r_xacc2[0] <= rcs_pkg::ACC_ONE;
            r_xf1[0]   <= w_ne[31:0];
            r_xs1[0]   <= 18'(w_ne >>> 32) + 18'sd1;
            r_xf2[0]   <= w_l[31:0];
            r_xs2[0]   <= 18'(w_l >>> 32) - 18'sd31;
            for (int i = 1; i <= ES; i++) begin
                r_xacc1[i] <= r_xf1[i-1][ES-i] ? w_xmul1[i] : r_xacc1[i-1];
                r_xacc2[i] <= r_xf2[i-1][ES-i] ? w_xmul2[i] : r_xacc2[i-1];
                r_xf1[i]   <= r_xf1[i-1];
                r_xf2[i]   <= r_xf2[i-1];
                r_xs1[i]   <= r_xs1[i-1];
                r_xs2[i]   <= r_xs2[i-1];
            end
            r_se  <= w_y1[64] ? 33'(rcs_pkg::CAP32)
                   : ((w_y1[63:0] > rcs_pkg::CAP32) ? 33'(rcs_pkg::CAP32) : 33'(w_y1[63:0]));
            r_mag <= w_y2[64] ? 48'(rcs_pkg::CAP47)
                   : ((w_y2[63:0] > rcs_pkg::CAP47) ? 48'(rcs_pkg::CAP47) : 48'(w_y2[63:0]));

            r_prod <= 50'(w_cfg.span) * 50'(r_se);
            r_zmag <= r_mag;
        end

        if (!r_o_valid || !i_stall) begin
            r_o_sat   <= r_pos[PD-1] ? w_sat_sum[16:0] : rcs_pkg::SAT_ONE;
            r_o_slope <= (r_pos[PD-1] && (w_cfg.span != 17'd0)) ? 48'(48'd0 - r_zmag)
                                                                 : 48'd0;
        end
    end

endmodule
